[design/delta_list_timer_queue_top_defines.svh]
// ----------------------------------------------------------------------------
// Delta list timer queue: assertion macros
// Shared property shapes for the checker that watches the top-level ports.
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_TIMER_QUEUE_TOP_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DLTQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("delta list timer queue: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DLTQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("delta list timer queue: next-cycle check failed");

`endif

[design/dltq_pkg.sv]
// ----------------------------------------------------------------------------
// Delta list timer queue package
// Sizes, command codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package dltq_pkg;

   localparam int TIMERS     = 16;
   localparam int ID_W       = $clog2(TIMERS);
   localparam int CNT_W      = $clog2(TIMERS + 1);

   localparam int KIND_W     = 2;
   localparam int TIMER_ID_W = 4;
   localparam int OWNER_W    = 8;
   localparam int DELAY_W    = 32;
   localparam int RKIND_W    = 2;
   localparam int STATUS_W   = 3;

   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

   localparam logic [RKIND_W-1:0] RES_ADD_DONE    = 2'd0;
   localparam logic [RKIND_W-1:0] RES_DELETE_DONE = 2'd1;
   localparam logic [RKIND_W-1:0] RES_EXPIRED     = 2'd2;
   localparam logic [RKIND_W-1:0] RES_IDLE_TICK   = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK             = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_ZERO_DELAY     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_ALREADY_QUEUED = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_QUEUE_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOT_QUEUED     = 3'd4;

   typedef logic [ID_W-1:0]  slot_idx_type;
   typedef logic [CNT_W-1:0] count_type;

   // Where a memory address or a flag index comes from.
   typedef enum logic {
      ADDR_SLOT,   // order slot at the walk position
      ADDR_ID      // handle of the word being worked on
   } addr_sel_type;

   typedef enum logic [1:0] {
      WR_SUB_REM,  // read delta minus remaining delay
      WR_REM,      // remaining delay
      WR_ADD_REM,  // read delta plus remaining delay
      WR_DEC       // read delta minus one
   } wr_op_type;

   typedef enum logic [1:0] {
      SRC_REQ,     // handle of the request, owner zero
      SRC_PEND,    // pending expired timer and its owner
      SRC_ZERO     // handle and owner zero
   } emit_src_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ADD_RD,
      ST_ADD_CMP,
      ST_INSERT,
      ST_DEL_FIND,
      ST_DEL_RD_ID,
      ST_DEL_LATCH,
      ST_DEL_ADD,
      ST_DEL_REMOVE,
      ST_TICK_RD,
      ST_TICK_FIRST,
      ST_TICK_RD2,
      ST_TICK_NEXT,
      ST_TICK_FLUSH
   } state_type;

   typedef struct packed {
      logic                  load;
      addr_sel_type          rd_sel;
      logic                  wr_en;
      addr_sel_type          wr_sel;
      wr_op_type             wr_op;
      logic                  owner_wr;
      logic                  pos_inc;
      logic                  mark_load;
      logic                  rem_sub;
      logic                  rem_load_rd;
      logic                  insert;
      logic                  remove;
      logic                  flag_clr;
      addr_sel_type          flag_sel;
      logic                  pend_load;
      logic                  emit;
      emit_src_type          emit_src;
      logic [RKIND_W-1:0]    emit_kind;
      logic [STATUS_W-1:0]   emit_status;
      logic                  emit_last;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              delay_zero;
      logic              id_oor;
      logic              id_queued;
      logic              full;
      logic              empty;
      logic              count_one;
      logic              at_end;
      logic              slot_match;
      logic              rem_lt_rd;
      logic              rd_zero;
      logic              rd_one;
   } stat_type;

endpackage

`default_nettype wire

[design/dltq_ctrl.sv]
// ----------------------------------------------------------------------------
// Delta list timer queue controller
// Sequences add, delete and tick words through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module dltq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output      logic              busy,
   input  wire dltq_pkg::stat_type stat,
   output      dltq_pkg::cmd_type  cmd
);

   dltq_pkg::state_type state_ff, state_in;
   logic                add_err;
   logic                del_err;
   logic                head_pops;

   assign add_err   = stat.delay_zero || stat.id_oor || stat.id_queued || stat.full;
   assign del_err   = stat.id_oor || !stat.id_queued;
   assign head_pops = stat.rd_zero || stat.rd_one;
   assign busy      = (state_ff != dltq_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dltq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dltq_pkg::ST_IDLE: begin
            if (start) state_in = dltq_pkg::ST_DISPATCH;
         end
         dltq_pkg::ST_DISPATCH: begin
            unique case (stat.kind)
               dltq_pkg::KIND_ADD:
                  state_in = add_err ? dltq_pkg::ST_IDLE : dltq_pkg::ST_ADD_RD;
               dltq_pkg::KIND_DELETE:
                  state_in = del_err ? dltq_pkg::ST_IDLE : dltq_pkg::ST_DEL_FIND;
               dltq_pkg::KIND_TICK:
                  state_in = stat.empty ? dltq_pkg::ST_IDLE : dltq_pkg::ST_TICK_RD;
               default:
                  state_in = dltq_pkg::ST_IDLE;
            endcase
         end
         dltq_pkg::ST_ADD_RD:
            state_in = stat.at_end ? dltq_pkg::ST_INSERT : dltq_pkg::ST_ADD_CMP;
         dltq_pkg::ST_ADD_CMP:
            state_in = stat.rem_lt_rd ? dltq_pkg::ST_INSERT : dltq_pkg::ST_ADD_RD;
         dltq_pkg::ST_INSERT:
            state_in = dltq_pkg::ST_IDLE;
         dltq_pkg::ST_DEL_FIND: begin
            if (stat.at_end) state_in = dltq_pkg::ST_IDLE;
            else if (stat.slot_match) state_in = dltq_pkg::ST_DEL_RD_ID;
         end
         dltq_pkg::ST_DEL_RD_ID:
            state_in = dltq_pkg::ST_DEL_LATCH;
         dltq_pkg::ST_DEL_LATCH:
            state_in = stat.at_end ? dltq_pkg::ST_DEL_REMOVE : dltq_pkg::ST_DEL_ADD;
         dltq_pkg::ST_DEL_ADD:
            state_in = dltq_pkg::ST_DEL_REMOVE;
         dltq_pkg::ST_DEL_REMOVE:
            state_in = dltq_pkg::ST_IDLE;
         dltq_pkg::ST_TICK_RD:
            state_in = dltq_pkg::ST_TICK_FIRST;
         dltq_pkg::ST_TICK_FIRST: begin
            if (!head_pops) state_in = dltq_pkg::ST_IDLE;
            else if (stat.count_one) state_in = dltq_pkg::ST_TICK_FLUSH;
            else state_in = dltq_pkg::ST_TICK_RD2;
         end
         dltq_pkg::ST_TICK_RD2:
            state_in = dltq_pkg::ST_TICK_NEXT;
         dltq_pkg::ST_TICK_NEXT: begin
            if (!stat.rd_zero) state_in = dltq_pkg::ST_IDLE;
            else if (stat.count_one) state_in = dltq_pkg::ST_TICK_FLUSH;
            else state_in = dltq_pkg::ST_TICK_RD2;
         end
         dltq_pkg::ST_TICK_FLUSH:
            state_in = dltq_pkg::ST_IDLE;
         default:
            state_in = dltq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rd_sel    = dltq_pkg::ADDR_SLOT;
      cmd.wr_sel    = dltq_pkg::ADDR_SLOT;
      cmd.flag_sel  = dltq_pkg::ADDR_SLOT;
      cmd.wr_op     = dltq_pkg::WR_SUB_REM;
      cmd.emit_src  = dltq_pkg::SRC_REQ;
      cmd.emit_last = 1'b1;
      unique case (state_ff)
         dltq_pkg::ST_IDLE:
            cmd.load = start;
         dltq_pkg::ST_DISPATCH: begin
            unique case (stat.kind)
               dltq_pkg::KIND_ADD: begin
                  cmd.emit      = add_err;
                  cmd.emit_kind = dltq_pkg::RES_ADD_DONE;
                  if (stat.delay_zero) cmd.emit_status = dltq_pkg::STAT_ZERO_DELAY;
                  else if (stat.id_oor) cmd.emit_status = dltq_pkg::STAT_QUEUE_FULL;
                  else if (stat.id_queued) cmd.emit_status = dltq_pkg::STAT_ALREADY_QUEUED;
                  else cmd.emit_status = dltq_pkg::STAT_QUEUE_FULL;
               end
               dltq_pkg::KIND_DELETE: begin
                  cmd.emit        = del_err;
                  cmd.emit_kind   = dltq_pkg::RES_DELETE_DONE;
                  cmd.emit_status = dltq_pkg::STAT_NOT_QUEUED;
               end
               dltq_pkg::KIND_TICK: begin
                  cmd.emit        = stat.empty;
                  cmd.emit_src    = dltq_pkg::SRC_ZERO;
                  cmd.emit_kind   = dltq_pkg::RES_IDLE_TICK;
                  cmd.emit_status = dltq_pkg::STAT_OK;
               end
               default: begin
                  cmd.emit = 1'b0;
               end
            endcase
         end
         dltq_pkg::ST_ADD_RD: begin
            cmd.rd_sel = dltq_pkg::ADDR_SLOT;
         end
         dltq_pkg::ST_ADD_CMP: begin
            if (stat.rem_lt_rd) begin
               cmd.wr_en = 1'b1;
               cmd.wr_op = dltq_pkg::WR_SUB_REM;
            end else begin
               cmd.rem_sub = 1'b1;
               cmd.pos_inc = 1'b1;
            end
         end
         dltq_pkg::ST_INSERT: begin
            cmd.insert      = 1'b1;
            cmd.wr_en       = 1'b1;
            cmd.wr_sel      = dltq_pkg::ADDR_ID;
            cmd.wr_op       = dltq_pkg::WR_REM;
            cmd.owner_wr    = 1'b1;
            cmd.emit        = 1'b1;
            cmd.emit_kind   = dltq_pkg::RES_ADD_DONE;
            cmd.emit_status = dltq_pkg::STAT_OK;
         end
         dltq_pkg::ST_DEL_FIND: begin
            if (stat.at_end) begin
               cmd.flag_clr    = 1'b1;
               cmd.flag_sel    = dltq_pkg::ADDR_ID;
               cmd.emit        = 1'b1;
               cmd.emit_kind   = dltq_pkg::RES_DELETE_DONE;
               cmd.emit_status = dltq_pkg::STAT_NOT_QUEUED;
            end else begin
               cmd.mark_load = stat.slot_match;
               cmd.pos_inc   = 1'b1;
            end
         end
         dltq_pkg::ST_DEL_RD_ID: begin
            cmd.rd_sel = dltq_pkg::ADDR_ID;
         end
         dltq_pkg::ST_DEL_LATCH: begin
            cmd.rem_load_rd = 1'b1;
         end
         dltq_pkg::ST_DEL_ADD: begin
            cmd.wr_en = 1'b1;
            cmd.wr_op = dltq_pkg::WR_ADD_REM;
         end
         dltq_pkg::ST_DEL_REMOVE: begin
            cmd.remove      = 1'b1;
            cmd.flag_clr    = 1'b1;
            cmd.flag_sel    = dltq_pkg::ADDR_ID;
            cmd.emit        = 1'b1;
            cmd.emit_kind   = dltq_pkg::RES_DELETE_DONE;
            cmd.emit_status = dltq_pkg::STAT_OK;
         end
         dltq_pkg::ST_TICK_RD, dltq_pkg::ST_TICK_RD2: begin
            cmd.rd_sel = dltq_pkg::ADDR_SLOT;
         end
         dltq_pkg::ST_TICK_FIRST: begin
            cmd.wr_en = !stat.rd_zero;
            cmd.wr_op = dltq_pkg::WR_DEC;
            if (head_pops) begin
               cmd.pend_load = 1'b1;
               cmd.remove    = 1'b1;
               cmd.flag_clr  = 1'b1;
            end else begin
               cmd.emit        = 1'b1;
               cmd.emit_src    = dltq_pkg::SRC_ZERO;
               cmd.emit_kind   = dltq_pkg::RES_IDLE_TICK;
               cmd.emit_status = dltq_pkg::STAT_OK;
            end
         end
         dltq_pkg::ST_TICK_NEXT: begin
            cmd.emit        = 1'b1;
            cmd.emit_src    = dltq_pkg::SRC_PEND;
            cmd.emit_kind   = dltq_pkg::RES_EXPIRED;
            cmd.emit_status = dltq_pkg::STAT_OK;
            cmd.emit_last   = !stat.rd_zero;
            if (stat.rd_zero) begin
               cmd.pend_load = 1'b1;
               cmd.remove    = 1'b1;
               cmd.flag_clr  = 1'b1;
            end
         end
         dltq_pkg::ST_TICK_FLUSH: begin
            cmd.emit        = 1'b1;
            cmd.emit_src    = dltq_pkg::SRC_PEND;
            cmd.emit_kind   = dltq_pkg::RES_EXPIRED;
            cmd.emit_status = dltq_pkg::STAT_OK;
         end
         default: begin
            cmd.load = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

[design/dltq_dpath.sv]
// ----------------------------------------------------------------------------
// Delta list timer queue datapath
// Order slots, delta and owner memories, walk registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dltq_dpath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire dltq_pkg::cmd_type                     cmd,
   output      dltq_pkg::stat_type                    stat,
   input  wire logic [dltq_pkg::KIND_W-1:0]           req_kind,
   input  wire logic [dltq_pkg::TIMER_ID_W-1:0]       req_timer_id,
   input  wire logic [dltq_pkg::OWNER_W-1:0]          req_owner,
   input  wire logic [dltq_pkg::DELAY_W-1:0]          req_delay,
   output      logic                                  rsp_strobe,
   output      logic [dltq_pkg::RKIND_W-1:0]          rsp_result_kind,
   output      logic [dltq_pkg::STATUS_W-1:0]         rsp_status,
   output      logic [dltq_pkg::TIMER_ID_W-1:0]       rsp_expired_timer,
   output      logic [dltq_pkg::OWNER_W-1:0]          rsp_expired_owner,
   output      logic                                  rsp_last
);

   // Latched request word.
   logic [dltq_pkg::KIND_W-1:0]     kind_ff;
   logic [dltq_pkg::TIMER_ID_W-1:0] id_ff;
   logic [dltq_pkg::OWNER_W-1:0]    own_ff;

   // Walk state.
   logic [dltq_pkg::DELAY_W-1:0] rem_ff, rem_in;
   dltq_pkg::count_type          pos_ff, pos_in;
   dltq_pkg::slot_idx_type       mark_ff, mark_in;

   // Queue state.
   dltq_pkg::count_type          count_ff, count_in;
   dltq_pkg::slot_idx_type       slot_ff [dltq_pkg::TIMERS];
   dltq_pkg::slot_idx_type       slot_in [dltq_pkg::TIMERS];
   dltq_pkg::slot_idx_type       slot_up [dltq_pkg::TIMERS];
   dltq_pkg::slot_idx_type       slot_dn [dltq_pkg::TIMERS];
   logic [dltq_pkg::TIMERS-1:0]  flag_ff, flag_in;

   logic [dltq_pkg::DELAY_W-1:0] delta_mem [dltq_pkg::TIMERS];
   logic [dltq_pkg::OWNER_W-1:0] owner_mem [dltq_pkg::TIMERS];
   logic [dltq_pkg::DELAY_W-1:0] rd_delta_ff;
   logic [dltq_pkg::OWNER_W-1:0] rd_owner_ff;

   // Expired timer waiting until it is known whether it is the last one.
   dltq_pkg::slot_idx_type       pend_timer_ff;
   logic [dltq_pkg::OWNER_W-1:0] pend_owner_ff;

   logic                                rsp_strobe_ff;
   logic [dltq_pkg::RKIND_W-1:0]        rsp_kind_ff;
   logic [dltq_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [dltq_pkg::TIMER_ID_W-1:0]     rsp_timer_ff, rsp_timer_in;
   logic [dltq_pkg::OWNER_W-1:0]        rsp_owner_ff, rsp_owner_in;
   logic                                rsp_last_ff;

   dltq_pkg::slot_idx_type       id_idx;
   dltq_pkg::slot_idx_type       pos_idx;
   dltq_pkg::slot_idx_type       head_slot;
   dltq_pkg::slot_idx_type       rd_addr;
   dltq_pkg::slot_idx_type       wr_addr;
   dltq_pkg::slot_idx_type       clr_addr;
   logic [dltq_pkg::DELAY_W-1:0] wr_data;

   assign id_idx    = dltq_pkg::ID_W'(id_ff);
   assign pos_idx   = pos_ff[dltq_pkg::ID_W-1:0];
   assign head_slot = slot_ff[pos_idx];
   assign rd_addr   = (cmd.rd_sel == dltq_pkg::ADDR_ID) ? id_idx : head_slot;
   assign wr_addr   = (cmd.wr_sel == dltq_pkg::ADDR_ID) ? id_idx : head_slot;
   assign clr_addr  = (cmd.flag_sel == dltq_pkg::ADDR_ID) ? id_idx : head_slot;

   always_comb begin
      stat.kind       = kind_ff;
      stat.delay_zero = (rem_ff == '0);
      stat.id_oor     = (32'(id_ff) >= 32'(dltq_pkg::TIMERS));
      stat.id_queued  = flag_ff[id_idx];
      stat.full       = (count_ff >= dltq_pkg::CNT_W'(dltq_pkg::TIMERS));
      stat.empty      = (count_ff == '0);
      stat.count_one  = (count_ff == dltq_pkg::CNT_W'(1));
      stat.at_end     = (pos_ff == count_ff);
      stat.slot_match = (head_slot == id_idx);
      stat.rem_lt_rd  = (rem_ff < rd_delta_ff);
      stat.rd_zero    = (rd_delta_ff == '0);
      stat.rd_one     = (rd_delta_ff == dltq_pkg::DELAY_W'(1));
   end

   always_comb begin
      case (cmd.wr_op)
         dltq_pkg::WR_SUB_REM: wr_data = rd_delta_ff - rem_ff;
         dltq_pkg::WR_REM:     wr_data = rem_ff;
         dltq_pkg::WR_ADD_REM: wr_data = rd_delta_ff + rem_ff;
         dltq_pkg::WR_DEC:     wr_data = rd_delta_ff - dltq_pkg::DELAY_W'(1);
         default:              wr_data = rem_ff;
      endcase
   end

   always_comb begin
      rem_in  = rem_ff;
      pos_in  = pos_ff;
      mark_in = mark_ff;
      if (cmd.load) begin
         rem_in  = req_delay;
         pos_in  = '0;
         mark_in = '0;
      end else begin
         if (cmd.rem_sub) rem_in = rem_ff - rd_delta_ff;
         if (cmd.rem_load_rd) rem_in = rd_delta_ff;
         if (cmd.pos_inc) pos_in = pos_ff + dltq_pkg::CNT_W'(1);
         if (cmd.mark_load) mark_in = pos_idx;
      end
   end

   // Neighbor views used by the insert and remove shifts of the order slots.
   always_comb begin
      slot_up[0] = slot_ff[0];
      for (int i = 1; i < dltq_pkg::TIMERS; i++) slot_up[i] = slot_ff[i-1];
      slot_dn[dltq_pkg::TIMERS-1] = slot_ff[dltq_pkg::TIMERS-1];
      for (int i = 0; i < dltq_pkg::TIMERS - 1; i++) slot_dn[i] = slot_ff[i+1];
   end

   always_comb begin
      for (int i = 0; i < dltq_pkg::TIMERS; i++) begin
         slot_in[i] = slot_ff[i];
         if (cmd.insert) begin
            if (dltq_pkg::CNT_W'(i) == pos_ff) slot_in[i] = id_idx;
            else if (dltq_pkg::CNT_W'(i) > pos_ff) slot_in[i] = slot_up[i];
         end else if (cmd.remove) begin
            if (dltq_pkg::ID_W'(i) >= mark_ff) slot_in[i] = slot_dn[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      flag_in  = flag_ff;
      if (cmd.insert) begin
         count_in        = count_ff + dltq_pkg::CNT_W'(1);
         flag_in[id_idx] = 1'b1;
      end
      if (cmd.remove) count_in = count_ff - dltq_pkg::CNT_W'(1);
      if (cmd.flag_clr) flag_in[clr_addr] = 1'b0;
   end

   always_comb begin
      case (cmd.emit_src)
         dltq_pkg::SRC_PEND: begin
            rsp_timer_in = dltq_pkg::TIMER_ID_W'(pend_timer_ff);
            rsp_owner_in = pend_owner_ff;
         end
         dltq_pkg::SRC_REQ: begin
            rsp_timer_in = id_ff;
            rsp_owner_in = '0;
         end
         default: begin
            rsp_timer_in = '0;
            rsp_owner_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         flag_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         flag_ff       <= flag_in;
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         id_ff   <= req_timer_id;
         own_ff  <= req_owner;
      end
      rem_ff  <= rem_in;
      pos_ff  <= pos_in;
      mark_ff <= mark_in;
      slot_ff <= slot_in;
      if (cmd.pend_load) begin
         pend_timer_ff <= head_slot;
         pend_owner_ff <= rd_owner_ff;
      end
      if (cmd.emit) begin
         rsp_kind_ff   <= cmd.emit_kind;
         rsp_status_ff <= cmd.emit_status;
         rsp_timer_ff  <= rsp_timer_in;
         rsp_owner_ff  <= rsp_owner_in;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) delta_mem[wr_addr] <= wr_data;
      if (cmd.owner_wr) owner_mem[id_idx] <= own_ff;
      rd_delta_ff <= delta_mem[rd_addr];
      rd_owner_ff <= owner_mem[rd_addr];
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_expired_timer = rsp_timer_ff;
   assign rsp_expired_owner = rsp_owner_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

[design/delta_list_timer_queue_top.sv]
// ----------------------------------------------------------------------------
// Delta list timer queue, top level
// Hardware timer queue that keeps up to sixteen timers as a delta list.
// ----------------------------------------------------------------------------
// A word is taken at a rising edge where start is high and busy is low, and
// the block then works on it alone until its last result is out. Results come
// on the rsp_ ports for exactly one cycle each, marked by rsp_strobe, and the
// receiver cannot hold them off; rsp_last marks the final result of a word.
// An add that is rejected, a delete of an unqueued timer and a tick on an
// empty queue are answered from the dispatch step alone. An accepted add
// walks the list through the delta memory, a read and then a compare and
// subtract for each entry passed, and lands at the tail or stops in front
// of the first entry that lies further out, whose delta it then shortens.
// A delete searches the order slots one per cycle and then does two memory
// reads and a write, the write being left out when the timer is the tail.
// A tick counts the head down and then pops every leading timer that has
// reached zero. The single read port of the delta memory paces all of these
// walks. busy drops in the cycle the last result shows, so the next word
// may be offered right then.
// Expired timers are reported in queue order, one per strobe, each with the
// owner stored when it was added. The queue resets empty; the delta and owner
// memories have no reset, and only their values for queued timers are used.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_list_timer_queue_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output      logic                                  busy,
   input  wire logic [dltq_pkg::KIND_W-1:0]           req_kind,
   input  wire logic [dltq_pkg::TIMER_ID_W-1:0]       req_timer_id,
   input  wire logic [dltq_pkg::OWNER_W-1:0]          req_owner,
   input  wire logic [dltq_pkg::DELAY_W-1:0]          req_delay,
   output      logic                                  rsp_strobe,
   output      logic [dltq_pkg::RKIND_W-1:0]          rsp_result_kind,
   output      logic [dltq_pkg::STATUS_W-1:0]         rsp_status,
   output      logic [dltq_pkg::TIMER_ID_W-1:0]       rsp_expired_timer,
   output      logic [dltq_pkg::OWNER_W-1:0]          rsp_expired_owner,
   output      logic                                  rsp_last
);

   // The controller issues one command bundle per cycle and steers on the
   // status bundle that the datapath returns; nothing else joins the two.
   dltq_pkg::cmd_type  cmd;
   dltq_pkg::stat_type stat;

   dltq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // The datapath holds the ordered slots, the per-timer delta and owner
   // memories, the walk registers and the result register.
   dltq_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_kind),
      .req_timer_id      (req_timer_id),
      .req_owner         (req_owner),
      .req_delay         (req_delay),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_status        (rsp_status),
      .rsp_expired_timer (rsp_expired_timer),
      .rsp_expired_owner (rsp_expired_owner),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

[design/dltq_checker.sv]
// ----------------------------------------------------------------------------
// Delta list timer queue port checker
// Watches the top-level ports for handshake and result ordering slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "delta_list_timer_queue_top_defines.svh"

module dltq_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  start,
   input wire logic                                  busy,
   input wire logic [dltq_pkg::KIND_W-1:0]           req_kind,
   input wire logic [dltq_pkg::TIMER_ID_W-1:0]       req_timer_id,
   input wire logic [dltq_pkg::OWNER_W-1:0]          req_owner,
   input wire logic [dltq_pkg::DELAY_W-1:0]          req_delay,
   input wire logic                                  rsp_strobe,
   input wire logic [dltq_pkg::RKIND_W-1:0]          rsp_result_kind,
   input wire logic [dltq_pkg::STATUS_W-1:0]         rsp_status,
   input wire logic [dltq_pkg::TIMER_ID_W-1:0]       rsp_expired_timer,
   input wire logic [dltq_pkg::OWNER_W-1:0]          rsp_expired_owner,
   input wire logic                                  rsp_last
);

   // An accepted word keeps the block busy in the following cycle.
   `DLTQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // More results of the same word are still to come, so the block is busy.
   `DLTQ_ASSERT_IMPLY(a_more_busy, clock, reset, rsp_strobe && !rsp_last, busy)

   // A new word passes through the dispatch state first, so results never abut
   // across words.
   `DLTQ_ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_strobe && rsp_last, !rsp_strobe)

   // Only expiries come in bursts and carry an owner.
   `DLTQ_ASSERT_IMPLY(a_single_result, clock, reset,
      rsp_strobe && (rsp_result_kind != dltq_pkg::RES_EXPIRED),
      rsp_last && (rsp_expired_owner == '0))

endmodule

bind delta_list_timer_queue_top dltq_checker u_dltq_checker (.*);

`default_nettype wire

[bench/tb_checker.sv]
// ----------------------------------------------------------------------------
// Timer queue checker
// Watches the word and result ports of the delta list timer queue. It keeps
// its own copy of the queue, works out the results of every accepted word
// and compares each strobed result with the oldest one still owed.
// ----------------------------------------------------------------------------
module tb_checker
   import dltq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [TIMER_ID_W-1:0] req_timer_id,
   input  logic [OWNER_W-1:0]    req_owner,
   input  logic [DELAY_W-1:0]    req_delay,
   input  logic                  rsp_strobe,
   input  logic [RKIND_W-1:0]    rsp_result_kind,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic [TIMER_ID_W-1:0] rsp_expired_timer,
   input  logic [OWNER_W-1:0]    rsp_expired_owner,
   input  logic                  rsp_last,
   output int unsigned           fail_count,
   output int unsigned           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [RKIND_W-1:0]    rkind;
      logic [STATUS_W-1:0]   status;
      logic [TIMER_ID_W-1:0] timer;
      logic [OWNER_W-1:0]    owner;
      logic                  last;
   } timer_event_type;

   // Shadow copy of the queue: handles head first, relative delays and owners.
   logic [TIMER_ID_W-1:0] slot_order [TIMERS];
   logic [DELAY_W-1:0]    delta_of   [TIMERS];
   logic [OWNER_W-1:0]    owner_of   [TIMERS];
   bit                    queued     [TIMERS];
   int                    depth;

   timer_event_type owed_events [$];

   function automatic timer_event_type make_event(input logic [RKIND_W-1:0] rkind,
         input logic [STATUS_W-1:0] status, input logic [TIMER_ID_W-1:0] timer,
         input logic [OWNER_W-1:0] owner, input logic last);
      timer_event_type ev;
      ev.rkind  = rkind;
      ev.status = status;
      ev.timer  = timer;
      ev.owner  = owner;
      ev.last   = last;
      return ev;
   endfunction

   function automatic void drop_slot(input int pos);
      int i;
      for (i = pos; i + 1 < depth; i++)
         slot_order[i] = slot_order[i + 1];
      depth--;
   endfunction

   // Walk the list, eating deltas, and slot the timer in front of the first
   // entry that lies further out; that entry keeps only the difference.
   function automatic logic [STATUS_W-1:0] insert_timer(input logic [TIMER_ID_W-1:0] id,
         input logic [OWNER_W-1:0] own, input logic [DELAY_W-1:0] delay);
      logic [DELAY_W-1:0] rem;
      int                 pos;
      int                 i;
      bit                 placed;
      rem    = delay;
      pos    = 0;
      placed = 1'b0;
      if (delay == '0) return STAT_ZERO_DELAY;
      if (int'(id) >= TIMERS) return STAT_QUEUE_FULL;
      if (queued[id]) return STAT_ALREADY_QUEUED;
      if (depth >= TIMERS) return STAT_QUEUE_FULL;
      while (pos < depth && !placed) begin
         if (rem < delta_of[slot_order[pos]]) begin
            delta_of[slot_order[pos]] = delta_of[slot_order[pos]] - rem;
            placed = 1'b1;
         end else begin
            rem = rem - delta_of[slot_order[pos]];
            pos++;
         end
      end
      for (i = depth; i > pos; i--)
         slot_order[i] = slot_order[i - 1];
      slot_order[pos] = id;
      delta_of[id]    = rem;
      owner_of[id]    = own;
      queued[id]      = 1'b1;
      depth++;
      return STAT_OK;
   endfunction

   // The successor inherits the delta of the removed timer.
   function automatic logic [STATUS_W-1:0] cancel_timer(input logic [TIMER_ID_W-1:0] id);
      int pos;
      pos = 0;
      if (int'(id) >= TIMERS || !queued[id]) return STAT_NOT_QUEUED;
      while (pos < depth && slot_order[pos] != id)
         pos++;
      if (pos >= depth) begin
         queued[id] = 1'b0;
         return STAT_NOT_QUEUED;
      end
      if (pos + 1 < depth)
         delta_of[slot_order[pos + 1]] = delta_of[slot_order[pos + 1]] + delta_of[id];
      drop_slot(pos);
      queued[id] = 1'b0;
      return STAT_OK;
   endfunction

   // One tick: count the head down, then pop every leading timer at zero.
   function automatic void advance_tick();
      int                    popped;
      logic [TIMER_ID_W-1:0] head;
      bit                    stop;
      popped = 0;
      stop   = 1'b0;
      if (depth > 0) begin
         head = slot_order[0];
         if (delta_of[head] != '0)
            delta_of[head] = delta_of[head] - 1'b1;
         while (depth > 0 && popped < 16 && !stop) begin
            head = slot_order[0];
            if (delta_of[head] != '0) begin
               stop = 1'b1;
            end else begin
               owed_events.push_back(make_event(RES_EXPIRED, STAT_OK, head,
                                                owner_of[head], 1'b0));
               popped++;
               queued[head] = 1'b0;
               drop_slot(0);
            end
         end
      end
      if (popped == 0)
         owed_events.push_back(make_event(RES_IDLE_TICK, STAT_OK, '0, '0, 1'b1));
      else
         owed_events[owed_events.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      timer_event_type seen;
      timer_event_type want;
      int              i;
      if (reset) begin
         depth = 0;
         for (i = 0; i < TIMERS; i++)
            queued[i] = 1'b0;
         owed_events.delete();
         fail_count = 0;
      end else begin
         // Results first: a new word may be taken at the edge that carries
         // the last result of the one before it.
         if (rsp_strobe) begin
            seen = make_event(rsp_result_kind, rsp_status, rsp_expired_timer,
                              rsp_expired_owner, rsp_last);
            if (owed_events.size() == 0) begin
               $display("%0t ns: unexpected result kind %0d status %0d timer %0d owner %0d last %0d",
                        $time, seen.rkind, seen.status, seen.timer, seen.owner, seen.last);
               fail_count++;
            end else begin
               want = owed_events.pop_front();
               if (seen !== want) begin
                  $display("%0t ns: mismatch, expected kind %0d status %0d timer %0d owner %0d last %0d",
                           $time, want.rkind, want.status, want.timer, want.owner, want.last);
                  $display("%0t ns:           actual kind %0d status %0d timer %0d owner %0d last %0d",
                           $time, seen.rkind, seen.status, seen.timer, seen.owner, seen.last);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            case (req_kind)
               KIND_ADD: begin
                  owed_events.push_back(make_event(RES_ADD_DONE,
                     insert_timer(req_timer_id, req_owner, req_delay),
                     req_timer_id, '0, 1'b1));
               end
               KIND_DELETE: begin
                  owed_events.push_back(make_event(RES_DELETE_DONE,
                     cancel_timer(req_timer_id), req_timer_id, '0, 1'b1));
               end
               KIND_TICK: begin
                  advance_tick();
               end
               default: begin
               end
            endcase
         end
      end
      outstanding = owed_events.size();
   end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// Timer queue testbench
// Drives add, delete and tick words into the delta list timer queue: a
// directed opening, then random words with random gaps. A checker beside the
// block predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dltq_pkg::*;

   // The fourth kind code has no meaning; the block must ignore it.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam int RANDOM_WORDS = 100;
   localparam logic [DELAY_W-1:0] DELAY_MAX = 32'hFFFF_FFFF;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [KIND_W-1:0]     req_kind;
   logic [TIMER_ID_W-1:0] req_timer_id;
   logic [OWNER_W-1:0]    req_owner;
   logic [DELAY_W-1:0]    req_delay;
   logic                  rsp_strobe;
   logic [RKIND_W-1:0]    rsp_result_kind;
   logic [STATUS_W-1:0]   rsp_status;
   logic [TIMER_ID_W-1:0] rsp_expired_timer;
   logic [OWNER_W-1:0]    rsp_expired_owner;
   logic                  rsp_last;
   int unsigned           fail_count;
   int unsigned           outstanding;

   delta_list_timer_queue_top u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_timer_id      (req_timer_id),
      .req_owner         (req_owner),
      .req_delay         (req_delay),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_status        (rsp_status),
      .rsp_expired_timer (rsp_expired_timer),
      .rsp_expired_owner (rsp_expired_owner),
      .rsp_last          (rsp_last)
   );

   tb_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_timer_id      (req_timer_id),
      .req_owner         (req_owner),
      .req_delay         (req_delay),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_status        (rsp_status),
      .rsp_expired_timer (rsp_expired_timer),
      .rsp_expired_owner (rsp_expired_owner),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Offer one word at the falling edge and hold it until the block takes it.
   // busy is read right after the rising edge, so it still holds the value
   // the block saw at that edge. start stays high if the next word follows
   // straight away.
   task automatic send_word(input logic [KIND_W-1:0] kind,
         input logic [TIMER_ID_W-1:0] id, input logic [OWNER_W-1:0] own,
         input logic [DELAY_W-1:0] delay);
      @(negedge clock);
      start        = 1'b1;
      req_kind     = kind;
      req_timer_id = id;
      req_owner    = own;
      req_delay    = delay;
      do @(posedge clock); while (busy);
   endtask

   // Sender gap: start goes low and the word ports carry junk meanwhile.
   // Since the gap begins right after a word is taken, its length decides
   // which step of the block's work the idle stretch covers.
   task automatic hold_off(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start        = 1'b0;
         req_kind     = KIND_W'($urandom);
         req_timer_id = TIMER_ID_W'($urandom);
         req_owner    = OWNER_W'($urandom);
         req_delay    = $urandom;
      end
   endtask

   // Stop sending until every owed result has come out.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   // Mostly short delays so that timers actually expire, with a share of
   // full-range, zero and near-maximum values.
   function automatic logic [DELAY_W-1:0] pick_delay();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) return DELAY_W'($urandom_range(1, 6));
      if (pick < 75) return DELAY_W'($urandom_range(1, 100));
      if (pick < 87) return $urandom;
      if (pick < 92) return '0;
      if (pick < 96) return DELAY_MAX;
      return DELAY_MAX - DELAY_W'($urandom_range(0, 15));
   endfunction

   initial begin : stimulus
      int                    sent;
      int                    pick;
      int                    i;
      logic [KIND_W-1:0]     kind;
      logic [TIMER_ID_W-1:0] id;

      reset        = 1'b1;
      start        = 1'b0;
      req_kind     = KIND_ADD;
      req_timer_id = '0;
      req_owner    = '0;
      req_delay    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed opening. A tick on the empty queue gives a single idle-tick
      // result, and an add with zero delay is refused.
      send_word(KIND_TICK, 4'd9, 8'h00, 32'd0);
      send_word(KIND_ADD, 4'd3, 8'h11, 32'd0);
      // Extremes: the top handle with the longest delay, then handle zero
      // with the shortest, which lands at the head and shortens the first.
      send_word(KIND_ADD, 4'd15, 8'h00, DELAY_MAX);
      send_word(KIND_ADD, 4'd0, 8'hFF, 32'd1);
      // A handle that is already queued is refused, and so is a delete of
      // one that is not queued. The unused kind is simply ignored.
      send_word(KIND_ADD, 4'd0, 8'h22, 32'd5);
      send_word(KIND_DELETE, 4'd7, 8'h00, 32'd0);
      send_word(KIND_UNUSED, 4'd1, 8'h33, 32'd1);
      // Same delay as the head: the new timer goes behind it with delta zero,
      // so the next tick expires both in one go.
      send_word(KIND_ADD, 4'd5, 8'hA5, 32'd1);
      send_word(KIND_TICK, 4'd0, 8'h00, 32'd0);
      drain();

      // Fill all sixteen entries with mixed short delays, many of them tied,
      // then try a handle that is queued while the queue is full.
      for (i = 0; i < 15; i++)
         send_word(KIND_ADD, TIMER_ID_W'(i), OWNER_W'(8'h40 + i * 13),
                   DELAY_W'((i * 7) % 5 + 1));
      send_word(KIND_ADD, 4'd3, 8'h5A, 32'd2);
      // Delete from the middle and from the tail, then tick twice so that
      // several timers expire on each tick.
      send_word(KIND_DELETE, 4'd7, 8'h00, 32'd0);
      send_word(KIND_DELETE, 4'd15, 8'h00, 32'd0);
      send_word(KIND_TICK, 4'd0, 8'h00, 32'd0);
      send_word(KIND_TICK, 4'd0, 8'h00, 32'd0);
      drain();

      // Random part. Stretches of twenty words alternate between filling the
      // queue and draining it with ticks. Ignored words do not count.
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         pick = $urandom_range(99);
         if ((sent / 20) % 2 == 0) begin
            if (pick < 60)      kind = KIND_ADD;
            else if (pick < 70) kind = KIND_DELETE;
            else if (pick < 96) kind = KIND_TICK;
            else                kind = KIND_UNUSED;
         end else begin
            if (pick < 25)      kind = KIND_ADD;
            else if (pick < 40) kind = KIND_DELETE;
            else if (pick < 96) kind = KIND_TICK;
            else                kind = KIND_UNUSED;
         end
         id = TIMER_ID_W'($urandom);
         send_word(kind, id, OWNER_W'($urandom), pick_delay());
         if (kind != KIND_UNUSED) begin
            sent++;
            // Twice in the run the sender waits for the queue of owed results
            // to empty before it goes on.
            if (sent == 60 || sent == 95)
               drain();
         end
         // No gaps at all from word 40 to word 90.
         if ((sent < 40 || sent > 90) && $urandom_range(99) < 10)
            hold_off($urandom_range(1, 20));
      end

      drain();
      // A tick that expires sixteen timers is the longest word the block has;
      // anything the block still puts out after the drain is caught here.
      repeat (100) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Hang guard, many times the slowest legal run.
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/dltq_pkg.sv
design/dltq_ctrl.sv
design/dltq_dpath.sv
design/delta_list_timer_queue_top.sv
design/dltq_checker.sv
bench/tb_checker.sv
bench/tb_top.sv
